// ===== hdl/sul_pkg.sv =====
// Shared types and constants for the sorted unique list unit.
`default_nettype none
package sul_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int DATA_W = 32;
	localparam int COUNT_OUT_W = 7;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_DUMP = 2'd2;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_REMOVED = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL = 3'd4;
	localparam logic [2:0] ST_DUMP_ENTRY = 3'd5;
	localparam logic [2:0] ST_EMPTY = 3'd6;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_REM,
		CELL_ROT
	} cell_op_t;

	typedef struct packed {
		logic cmp;
		cell_op_t op;
	} cell_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/sul_cell.sv =====
// One list cell: holds an entry, compares it with the key and shifts with its neighbors.
`default_nettype none
module sul_cell (
	input wire logic clk,
	input wire sul_pkg::cell_cmd_t cmd,
	input wire logic valid,
	input wire logic signed [sul_pkg::DATA_W-1:0] key,
	input wire logic prev_lt,
	input wire logic signed [sul_pkg::DATA_W-1:0] prev_entry,
	input wire logic signed [sul_pkg::DATA_W-1:0] next_entry,
	output logic signed [sul_pkg::DATA_W-1:0] entry,
	output logic lt,
	output logic eq
);

	logic signed [sul_pkg::DATA_W-1:0] entry_q;
	logic lt_q;
	logic eq_q;

	// Compare results are registered; the shift uses them in the next cycle.
	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			lt_q <= valid && (entry_q < key);
			eq_q <= valid && (entry_q == key);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			sul_pkg::CELL_INS: begin
				if (!lt_q) begin
					entry_q <= prev_lt ? key : prev_entry;
				end
			end
			sul_pkg::CELL_REM: begin
				if (!lt_q) begin
					entry_q <= next_entry;
				end
			end
			sul_pkg::CELL_ROT: begin
				entry_q <= next_entry;
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

	assign entry = entry_q;
	assign lt = lt_q;
	assign eq = eq_q;

endmodule
`default_nettype wire

// ===== hdl/sorted_unique_list_unit.sv =====
// Top level of the sorted unique list unit: control sequencer and the chain of list cells.
`default_nettype none
// Channel   Handshake           Payload                                  Direction
// command   start / busy        func, value                              in
// result    strobe (no stall)   status, entry_value, count_now, last     out
//
// An item is taken at a clock edge with start high and busy low.
// Insert and remove run from the accepting edge through S_CMP and S_APPLY: the edge accepts,
// then every cell compares its entry with the key, then the chain shifts and the result is
// registered. A dump of N entries rotates the chain by one cell per cycle and cell 0 feeds
// the result port, so after N steps the list is back in its original order.
// A dump of an empty list and an unused code finish at the accepting edge.
// Reset clears the count and the sequencer at once; entries need no clearing pass, since
// only cells below the count are ever compared or shown. Results cannot be stalled.
module sorted_unique_list_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] func,
	input wire logic signed [31:0] value,
	output logic strobe,
	output logic [2:0] status,
	output logic signed [31:0] entry_value,
	output logic [6:0] count_now,
	output logic last
);

	localparam int CAP = sul_pkg::CAPACITY;
	localparam int CW = sul_pkg::CNT_W;
	localparam int IW = sul_pkg::IDX_W;

	// One-hot sequencer states.
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CMP = 4'b0010,
		S_APPLY = 4'b0100,
		S_DUMP = 4'b1000
	} state_t;

	state_t state_q;
	logic [1:0] func_q;
	logic signed [sul_pkg::DATA_W-1:0] key_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] idx_q;

	logic strobe_q;
	logic [2:0] status_q;
	logic signed [sul_pkg::DATA_W-1:0] entry_value_q;
	logic [sul_pkg::COUNT_OUT_W-1:0] count_now_q;
	logic last_q;

	sul_pkg::cell_cmd_t cmd;
	logic signed [sul_pkg::DATA_W-1:0] cell_entry [CAP];
	logic [CAP-1:0] cell_lt;
	logic [CAP-1:0] cell_eq;
	logic found;
	logic full;
	logic accept;
	logic dump_last;

	assign accept = start && (state_q == S_IDLE);
	assign found = |cell_eq;
	assign full = (count_q == CW'(CAP));
	assign dump_last = (idx_q == IW'(count_q - CW'(1)));

	// The chain of cells. Cell 0 has no lower neighbor and takes the key when an insert
	// reaches it; the last valid cell wraps to cell 0 so that a dump rotates the list.
	for (genvar i = 0; i < CAP; i++) begin : g_cell
		logic valid_c;
		logic prev_lt_c;
		logic signed [sul_pkg::DATA_W-1:0] prev_c;
		logic signed [sul_pkg::DATA_W-1:0] next_c;

		assign valid_c = (count_q > CW'(i));

		if (i == 0) begin : g_first
			assign prev_lt_c = 1'b1;
			assign prev_c = key_q;
		end else begin : g_inner
			assign prev_lt_c = cell_lt[i-1];
			assign prev_c = cell_entry[i-1];
		end

		if (i == CAP - 1) begin : g_top
			assign next_c = cell_entry[0];
		end else begin : g_below
			assign next_c = (count_q == CW'(i + 1)) ? cell_entry[0] : cell_entry[i+1];
		end

		sul_cell u_cell (
			.clk(clk),
			.cmd(cmd),
			.valid(valid_c),
			.key(key_q),
			.prev_lt(prev_lt_c),
			.prev_entry(prev_c),
			.next_entry(next_c),
			.entry(cell_entry[i]),
			.lt(cell_lt[i]),
			.eq(cell_eq[i])
		);
	end

	// Command broadcast to every cell.
	always_comb begin
		cmd.cmp = (state_q == S_CMP);
		cmd.op = sul_pkg::CELL_HOLD;
		case (state_q)
			S_APPLY: begin
				if (func_q == sul_pkg::FUNC_INSERT && !found && !full) begin
					cmd.op = sul_pkg::CELL_INS;
				end else if (func_q == sul_pkg::FUNC_REMOVE && found) begin
					cmd.op = sul_pkg::CELL_REM;
				end
			end
			S_DUMP: begin
				cmd.op = sul_pkg::CELL_ROT;
			end
			default: begin
				cmd.op = sul_pkg::CELL_HOLD;
			end
		endcase
	end

	// Command capture; payload registers need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			key_q <= value;
		end
	end

	// Sequencer, count and dump index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (func == sul_pkg::FUNC_INSERT || func == sul_pkg::FUNC_REMOVE) begin
							state_q <= S_CMP;
						end else if (func == sul_pkg::FUNC_DUMP) begin
							if (count_q == '0) begin
								strobe_q <= 1'b1;
							end else begin
								state_q <= S_DUMP;
								idx_q <= '0;
							end
						end
					end
				end
				S_CMP: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					strobe_q <= 1'b1;
					state_q <= S_IDLE;
					if (cmd.op == sul_pkg::CELL_INS) begin
						count_q <= count_q + CW'(1);
					end else if (cmd.op == sul_pkg::CELL_REM) begin
						count_q <= count_q - CW'(1);
					end
				end
				S_DUMP: begin
					strobe_q <= 1'b1;
					idx_q <= idx_q + IW'(1);
					if (dump_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload, registered alongside the strobe.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				status_q <= sul_pkg::ST_EMPTY;
				entry_value_q <= '0;
				count_now_q <= '0;
				last_q <= 1'b1;
			end
			S_APPLY: begin
				entry_value_q <= '0;
				last_q <= 1'b1;
				count_now_q <= sul_pkg::COUNT_OUT_W'(count_q);
				if (func_q == sul_pkg::FUNC_INSERT) begin
					if (found) begin
						status_q <= sul_pkg::ST_DUPLICATE;
					end else if (full) begin
						status_q <= sul_pkg::ST_FULL;
					end else begin
						status_q <= sul_pkg::ST_INSERTED;
						count_now_q <= sul_pkg::COUNT_OUT_W'(count_q + CW'(1));
					end
				end else begin
					if (found) begin
						status_q <= sul_pkg::ST_REMOVED;
						count_now_q <= sul_pkg::COUNT_OUT_W'(count_q - CW'(1));
					end else begin
						status_q <= sul_pkg::ST_NOT_FOUND;
					end
				end
			end
			S_DUMP: begin
				status_q <= sul_pkg::ST_DUMP_ENTRY;
				entry_value_q <= cell_entry[0];
				count_now_q <= sul_pkg::COUNT_OUT_W'(count_q);
				last_q <= dump_last;
			end
			default: begin
				status_q <= status_q;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign status = status_q;
	assign entry_value = entry_value_q;
	assign count_now = count_now_q;
	assign last = last_q;

endmodule
`default_nettype wire
